FILE: design/gregorian_date_arithmetic_macros.svh
// gregorian_date_arithmetic_macros.svh: assertion macros for the date block.
// No dependencies; the including module provides clk and rst.
`ifndef GREGORIAN_DATE_ARITHMETIC_MACROS_SVH
`define GREGORIAN_DATE_ARITHMETIC_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define GDA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gda assertion failed");
// next-cycle implication
`define GDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gda assertion failed");
`else
`define GDA_ASSERT_IMPL(lbl, ante, cons)
`define GDA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: design/gda_pkg.sv
// gda_pkg: widths, word layout, command/status structs and calendar tables
// for the Gregorian date block. No dependencies.
package gda_pkg;

  localparam int DayW    = 5;
  localparam int MonW    = 4;
  localparam int YearW   = 14;
  localparam int CntW    = 16;
  localparam int SerW    = 23;  // day serial, 1.1.0001 is day 1
  localparam int DiffW   = 23;
  localparam int ModeW   = 2;
  localparam int LvlW    = 2;
  localparam int DigW    = 6;   // up to 63 four-century steps
  localparam int CumW    = 9;

  localparam int MaxYearDefault = 9999;

  // input word layout
  localparam int InDataW    = 64;
  localparam int InADayLsb  = 0;
  localparam int InAMonLsb  = 5;
  localparam int InAYearLsb = 9;
  localparam int InBDayLsb  = 23;
  localparam int InBMonLsb  = 28;
  localparam int InBYearLsb = 32;
  localparam int InCountLsb = 46;

  // output word layout
  localparam int OutDataW    = 56;
  localparam int OutDayLsb   = 0;
  localparam int OutMonLsb   = 5;
  localparam int OutYearLsb  = 9;
  localparam int OutDiffLsb  = 23;
  localparam int OutLessBit  = 46;
  localparam int OutEqualBit = 47;
  localparam int OutErrBit   = 48;
  localparam int OutUsedW    = 49;

  typedef logic [SerW-1:0] serial_t;

  typedef enum logic [ModeW-1:0] {
    MODE_NORM = 2'd0,
    MODE_ADD  = 2'd1,
    MODE_SUB  = 2'd2,
    MODE_DIFF = 2'd3
  } mode_t;

  // digit levels of the year/day decomposition
  localparam logic [LvlW-1:0] LVL_400 = 2'd0;
  localparam logic [LvlW-1:0] LVL_100 = 2'd1;
  localparam logic [LvlW-1:0] LVL_4   = 2'd2;
  localparam logic [LvlW-1:0] LVL_1   = 2'd3;

  localparam logic [MonW-1:0] MonFirst = 4'd1;
  localparam logic [MonW-1:0] MonFeb   = 4'd2;
  localparam logic [MonW-1:0] MonLast  = 4'd12;

  typedef struct packed {
    logic load_in;
    logic sel_b;
    logic enc_init;
    logic digit_step;
    logic dec;
    logic enc_fin;
    logic op;
    logic dec_init;
    logic mon_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic coarse_ok;
    logic digit_done;
    logic mon_done;
    logic diff_mode;
    logic out_busy;
  } stat_t;

  function automatic logic [DayW-1:0] month_days(input logic [MonW-1:0] m, input logic leap);
    logic [DayW-1:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:    d = leap ? 5'd29 : 5'd28;
      default: d = '0;
    endcase
    return d;
  endfunction

  // days in the year before the first of month m
  function automatic logic [CumW-1:0] days_before_month(input logic [MonW-1:0] m,
                                                        input logic leap);
    logic [CumW-1:0] base;
    case (m)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + CumW'(leap && (m > MonFeb));
  endfunction

  // step size per level: days when decoding a serial, years when encoding
  function automatic serial_t unit_size(input logic [LvlW-1:0] lvl, input logic in_days);
    serial_t u;
    case (lvl)
      LVL_400: u = in_days ? 23'd146097 : 23'd400;
      LVL_100: u = in_days ? 23'd36524  : 23'd100;
      LVL_4:   u = in_days ? 23'd1461   : 23'd4;
      LVL_1:   u = in_days ? 23'd365    : 23'd1;
      default: u = '0;
    endcase
    return u;
  endfunction

endpackage

FILE: design/gda_ctrl.sv
// gda_ctrl: sequencer for the date block; walks each item through encode,
// operate, decode and output. Depends on gda_pkg.
module gda_ctrl import gda_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_ENC_INIT = 9'b000000010,
    S_ENC_RUN  = 9'b000000100,
    S_ENC_FIN  = 9'b000001000,
    S_OP       = 9'b000010000,
    S_DEC_INIT = 9'b000100000,
    S_DEC_RUN  = 9'b001000000,
    S_MON      = 9'b010000000,
    S_OUT      = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   sel_b, sel_b_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel_b <= 1'b0;
    end else begin
      state <= state_next;
      sel_b <= sel_b_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_b_next = sel_b;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.sel_b  = sel_b;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          sel_b_next  = 1'b0;
          state_next  = S_ENC_INIT;
        end
      end
      S_ENC_INIT: begin
        cmd.enc_init = 1'b1;
        if (stat.coarse_ok) begin
          state_next = S_ENC_RUN;
        end else if (!sel_b && stat.diff_mode) begin
          sel_b_next = 1'b1;
          state_next = S_ENC_INIT;
        end else begin
          state_next = S_OP;
        end
      end
      S_ENC_RUN: begin
        cmd.digit_step = 1'b1;
        if (stat.digit_done) state_next = S_ENC_FIN;
      end
      S_ENC_FIN: begin
        cmd.enc_fin = 1'b1;
        if (!sel_b && stat.diff_mode) begin
          sel_b_next = 1'b1;
          state_next = S_ENC_INIT;
        end else begin
          state_next = S_OP;
        end
      end
      S_OP: begin
        cmd.op     = 1'b1;
        state_next = S_DEC_INIT;
      end
      S_DEC_INIT: begin
        cmd.dec_init = 1'b1;
        state_next   = S_DEC_RUN;
      end
      S_DEC_RUN: begin
        cmd.digit_step = 1'b1;
        cmd.dec        = 1'b1;
        if (stat.digit_done) state_next = S_MON;
      end
      S_MON: begin
        cmd.mon_step = 1'b1;
        if (stat.mon_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: design/gda_datapath.sv
// gda_datapath: operand registers, shared digit unit (year <-> day serial),
// month stepper, add/subtract/compare and the output word register. Depends on gda_pkg.
module gda_datapath import gda_pkg::*; #(
  parameter int MAX_YEAR = MaxYearDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output stat_t                stat,
  input  logic [InDataW-1:0]   in_data,
  input  logic [ModeW-1:0]     in_user,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [OutDataW-1:0]  out_data
);

  localparam int LastInt = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;
  localparam serial_t         LastSerial = SerW'(LastInt);
  localparam serial_t         SerialOne  = 23'd1;
  localparam logic [YearW-1:0] YearMax   = YearW'(MAX_YEAR);
  localparam logic [DigW-1:0] DigCap     = 6'd3;
  localparam logic [4:0]      LastN4     = 5'd24;
  localparam logic [1:0]      LastN100   = 2'd3;

  mode_t             mode;
  logic [DayW-1:0]   a_day, b_day;
  logic [MonW-1:0]   a_month, b_month;
  logic [YearW-1:0]  a_year, b_year;
  logic [CntW-1:0]   day_count;

  serial_t           sa, sb, sr, q, acc;
  logic [LvlW-1:0]   level;
  logic [DigW-1:0]   dig;
  logic [1:0]        n100;
  logic [4:0]        n4;
  logic [MonW-1:0]   mon;
  logic signed [DiffW-1:0] diff;
  logic              less, equal, err;

  logic [DayW-1:0]   sel_day;
  logic [MonW-1:0]   sel_month;
  logic [YearW-1:0]  sel_year;
  logic              coarse_ok, leap, capped, can_step, day_fits, mon_can;
  serial_t           uq, ua, enc_serial, enc_result;
  logic [DayW-1:0]   mdays_sel, mdays_mon;

  serial_t           sr_next;
  logic              err_next, less_next, equal_next, fits;
  logic [SerW:0]     sum;
  logic signed [SerW:0]    dfull;
  logic signed [DiffW-1:0] diff_next;
  logic [OutDataW-1:0] out_word;

  assign sel_day   = cmd.sel_b ? b_day   : a_day;
  assign sel_month = cmd.sel_b ? b_month : a_month;
  assign sel_year  = cmd.sel_b ? b_year  : a_year;

  assign coarse_ok = (sel_year != '0) && (sel_year <= YearMax) && (sel_month >= MonFirst) &&
                     (sel_month <= MonLast) && (sel_day != '0);

  // digit unit: q is the remaining quantity, acc collects the other unit
  assign uq       = unit_size(level, cmd.dec);
  assign ua       = unit_size(level, !cmd.dec);
  assign capped   = ((level == LVL_100) || (level == LVL_1)) && (dig == DigCap);
  assign can_step = !capped && (q >= uq);

  // leap: last year of a four-year group, not a plain century end
  assign leap = (dig == DigCap) && ((n4 != LastN4) || (n100 == LastN100));

  assign mdays_sel  = month_days(sel_month, leap);
  assign mdays_mon  = month_days(mon, leap);
  assign day_fits   = sel_day <= mdays_sel;
  assign enc_serial = acc + {{(SerW-CumW){1'b0}}, days_before_month(sel_month, leap)} +
                      {{(SerW-DayW){1'b0}}, sel_day};
  assign enc_result = day_fits ? enc_serial : SerialOne;
  assign mon_can    = (mon != MonLast) && (q >= {{(SerW-DayW){1'b0}}, mdays_mon});

  assign stat.coarse_ok  = coarse_ok;
  assign stat.digit_done = !can_step && (level == LVL_1);
  assign stat.mon_done   = !mon_can;
  assign stat.diff_mode  = (mode == MODE_DIFF);
  assign stat.out_busy   = out_valid && !out_ready;

  // operation on the serials
  assign sum   = {1'b0, sa} + {{(SerW+1-CntW){1'b0}}, day_count};
  assign dfull = $signed({1'b0, sa}) - $signed({1'b0, sb});
  assign fits  = (dfull[SerW:DiffW-1] == '0) || (dfull[SerW:DiffW-1] == '1);

  always_comb begin
    sr_next    = sa;
    err_next   = 1'b0;
    less_next  = 1'b0;
    equal_next = 1'b0;
    diff_next  = '0;
    case (mode)
      MODE_ADD: begin
        if (sum > {1'b0, LastSerial}) begin
          sr_next  = LastSerial;
          err_next = 1'b1;
        end else begin
          sr_next = sum[SerW-1:0];
        end
      end
      MODE_SUB: begin
        if ({{(SerW-CntW){1'b0}}, day_count} >= sa) begin
          sr_next  = SerialOne;
          err_next = 1'b1;
        end else begin
          sr_next = sa - {{(SerW-CntW){1'b0}}, day_count};
        end
      end
      MODE_DIFF: begin
        less_next  = sa < sb;
        equal_next = sa == sb;
        if (fits) begin
          diff_next = $signed(dfull[DiffW-1:0]);
        end else if (dfull[SerW]) begin
          diff_next = $signed({1'b1, {(DiffW-1){1'b0}}});
        end else begin
          diff_next = $signed({1'b0, {(DiffW-1){1'b1}}});
        end
      end
      default: sr_next = sa;
    endcase
  end

  always_comb begin
    out_word = '0;
    out_word[OutDayLsb +: DayW]   = q[DayW-1:0] + DayW'(1);
    out_word[OutMonLsb +: MonW]   = mon;
    out_word[OutYearLsb +: YearW] = acc[YearW-1:0] + YearW'(1);
    out_word[OutDiffLsb +: DiffW] = diff;
    out_word[OutLessBit]          = less;
    out_word[OutEqualBit]         = equal;
    out_word[OutErrBit]           = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode      <= mode_t'(in_user);
      a_day     <= in_data[InADayLsb +: DayW];
      a_month   <= in_data[InAMonLsb +: MonW];
      a_year    <= in_data[InAYearLsb +: YearW];
      b_day     <= in_data[InBDayLsb +: DayW];
      b_month   <= in_data[InBMonLsb +: MonW];
      b_year    <= in_data[InBYearLsb +: YearW];
      day_count <= in_data[InCountLsb +: CntW];
    end
    if (cmd.enc_init) begin
      if (coarse_ok) begin
        q     <= {{(SerW-YearW){1'b0}}, sel_year - YearW'(1)};
        acc   <= '0;
        level <= LVL_400;
        dig   <= '0;
      end else if (cmd.sel_b) begin
        sb <= SerialOne;
      end else begin
        sa <= SerialOne;
      end
    end
    if (cmd.digit_step) begin
      if (can_step) begin
        q   <= q - uq;
        acc <= acc + ua;
        dig <= dig + DigW'(1);
      end else if (level != LVL_1) begin
        if (level == LVL_100) n100 <= dig[1:0];
        if (level == LVL_4)   n4   <= dig[4:0];
        level <= level + LvlW'(1);
        dig   <= '0;
      end
    end
    if (cmd.enc_fin) begin
      if (cmd.sel_b) sb <= enc_result;
      else           sa <= enc_result;
    end
    if (cmd.op) begin
      sr    <= sr_next;
      err   <= err_next;
      less  <= less_next;
      equal <= equal_next;
      diff  <= diff_next;
    end
    if (cmd.dec_init) begin
      q     <= sr - SerialOne;
      acc   <= '0;
      level <= LVL_400;
      dig   <= '0;
      mon   <= MonFirst;
    end
    if (cmd.mon_step && mon_can) begin
      q   <= q - {{(SerW-DayW){1'b0}}, mdays_mon};
      mon <= mon + MonW'(1);
    end
    if (cmd.out_load) out_data <= out_word;
  end

endmodule

FILE: design/gregorian_date_arithmetic.sv
// gregorian_date_arithmetic: top level of the Gregorian date block; uses gda_pkg, gda_ctrl,
// gda_datapath and the assertion macros. One item at a time: each item passes through the
// shared digit unit (an init, digit steps and a finish per date encode, two encodes in
// difference mode, then an init and digit steps for the decode) and the month stepper
// before the result word loads. The next word can be taken in the cycle after the result
// loads; rst (sync, active high) idles the sequencer and empties the output.
`include "gregorian_date_arithmetic_macros.svh"

module gregorian_date_arithmetic import gda_pkg::*; #(
  parameter int MAX_YEAR = MaxYearDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // a_day, a_month, a_year, b_day, b_month, b_year, day_count, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // mode
  input  logic [ModeW-1:0]    s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // res_day, res_month, res_year, day_difference, a_less, a_equal, range_error, zero pad
  output logic [OutDataW-1:0] m_axis_tdata
);

  // The controller only issues commands; the datapath reports back status.
  // Per item: latch the word, turn date A (and date B in difference mode)
  // into a day serial by peeling 400/100/4/1-year groups, do the operation
  // on serials, then turn the result serial back into year, month and day.
  cmd_t  cmd;
  stat_t stat;

  gda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  gda_datapath #(
    .MAX_YEAR (MAX_YEAR)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

  // result word fields, for the checks below
  logic [MonW-1:0]  out_month;
  logic [DiffW-1:0] out_diff;
  logic             out_less, out_equal, out_err;

  assign out_month = m_axis_tdata[OutMonLsb +: MonW];
  assign out_diff  = m_axis_tdata[OutDiffLsb +: DiffW];
  assign out_less  = m_axis_tdata[OutLessBit];
  assign out_equal = m_axis_tdata[OutEqualBit];
  assign out_err   = m_axis_tdata[OutErrBit];

  // an accepted word makes the block busy in the next cycle
  `GDA_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // month stepper always lands on a real month
  `GDA_ASSERT_IMPL(a_month_range, m_axis_tvalid, (out_month >= MonFirst) && (out_month <= MonLast))
  // compare flags are exclusive
  `GDA_ASSERT_IMPL(a_flags_excl, m_axis_tvalid, !(out_less && out_equal))
  // equal dates give a zero difference
  `GDA_ASSERT_IMPL(a_equal_zero, m_axis_tvalid && out_equal, out_diff == '0)
  // range error only comes from add or subtract, which never compare
  `GDA_ASSERT_IMPL(a_err_no_cmp, m_axis_tvalid && out_err, !out_less && !out_equal)

endmodule
